// File: rtl/core/bta_pkg.sv
`timescale 1ns / 1ps

package bta_pkg;

  // Default pool geometry: 64 leaves of 1 MiB each.
  localparam int TREE_LEVELS_DEF = 6;
  localparam int LEAF_BYTES_DEF  = 1024 * 1024;

  // Fixed field widths of the stream payloads.
  localparam int REQ_SIZE_W = 32;
  localparam int OFFSET_W   = 6;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  // Request kinds carried on in_tuser.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic load;
    logic lvl_step;
    logic walk_start;
    logic descend;
    logic skip;
    logic skip_cand;
    logic mark_cand;
    logic grant_here;
    logic grant_cand;
    logic fr_apply;
    logic fr_next;
    logic push;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic req_ok;
    logic off_ok;
    logic lvl_hit;
    logic used;
    logic below;
    logic at_cand;
    logic at_leaf;
    logic leave_cand;
    logic skip_end;
    logic cand_end;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/core/buddy_tree_allocator.sv
// Flow: a free checks the node store one depth at a time, a read state and then a write
// state per depth from the root to the leaf level; an allocate first finds the grant level
// and then walks the tree in preorder, reading and checking each node that it visits.
// One request at a time: the next request is taken only after the result is registered,
// and a result held back by out_tready keeps the block from taking the next one.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the node store
// before the first request is taken.
`timescale 1ns / 1ps

module buddy_tree_allocator #(
  parameter int TREE_LEVELS = bta_pkg::TREE_LEVELS_DEF,
  parameter int LEAF_BYTES  = bta_pkg::LEAF_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bta_pkg::IN_DATA_W-1:0]    in_tdata,  // request_size, free_offset
  input  logic                             in_tuser,  // command
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bta_pkg::OUT_DATA_W-1:0]   out_tdata  // granted, block_offset
);

  bta_pkg::dp_cmd_t    cmd;
  bta_pkg::dp_status_t status;

  bta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bta_dpath #(
    .TREE_LEVELS (TREE_LEVELS),
    .LEAF_BYTES  (LEAF_BYTES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: rtl/core/bta_dpath.sv
`timescale 1ns / 1ps

module bta_dpath #(
  parameter int TREE_LEVELS = bta_pkg::TREE_LEVELS_DEF,
  parameter int LEAF_BYTES  = bta_pkg::LEAF_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bta_pkg::dp_cmd_t                 cmd,
  output bta_pkg::dp_status_t              status,
  input  logic                             in_tuser,
  input  logic [bta_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bta_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int NODE_W     = TREE_LEVELS + 1;
  localparam int NODE_SLOTS = 1 << NODE_W;
  localparam int DEP_W      = $clog2(TREE_LEVELS + 2);
  localparam int SIZE_W     = TREE_LEVELS + 32;
  localparam int OFS_W      = bta_pkg::OFFSET_W;
  localparam logic [SIZE_W-1:0] POOL_BYTES = SIZE_W'(LEAF_BYTES) << TREE_LEVELS;

  // Node store, indexed by heap number (slot 0 is never used).
  logic node_used_mem [NODE_SLOTS];

  logic [NODE_W-1:0]              clr_cnt_r;
  logic                           cmd_r;
  logic [bta_pkg::REQ_SIZE_W-1:0] size_r;
  logic [OFS_W-1:0]               off_r;
  logic [SIZE_W-1:0]              whole_r;
  logic [DEP_W-1:0]               dt_r;
  logic [DEP_W-1:0]               depth_r;
  logic [NODE_W-1:0]              idx_r;
  logic [NODE_W-1:0]              cand_r;
  logic                           rd_data_r;
  logic                           res_ok_r;
  logic [OFS_W-1:0]               res_off_r;
  logic                           out_valid_r;
  logic [bta_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [SIZE_W-1:0]        size_ext;
  logic [NODE_W:0]          idx_inc;
  logic [NODE_W:0]          cand_inc;
  logic [DEP_W-1:0]         t_idx;
  logic [DEP_W-1:0]         t_cand;
  logic [NODE_W:0]          idx_tgt;
  logic [NODE_W:0]          cand_tgt;
  logic [NODE_W:0]          lv_mask;
  logic [TREE_LEVELS-1:0]   off_l;
  logic [TREE_LEVELS-1:0]   off_sh;
  logic                     aligned;
  logic [NODE_W-1:0]        fslot;
  logic [NODE_W-1:0]        gnode;
  logic [NODE_W-1:0]        gnode_sh;
  logic [OFS_W-1:0]         gnode_off;
  logic [OFS_W-1:0]         push_off;
  logic                     we;
  logic [NODE_W-1:0]        waddr;
  logic                     wdata;
  logic [NODE_W-1:0]        raddr;

  // Position of the lowest set bit; the argument is never zero.
  function automatic logic [DEP_W-1:0] ctz(input logic [NODE_W:0] v);
    logic [DEP_W-1:0] n;
    n = '0;
    for (int i = NODE_W; i >= 0; i--) begin
      if (v[i]) begin
        n = DEP_W'(i);
      end
    end
    return n;
  endfunction

  assign size_ext = SIZE_W'(size_r);

  // Preorder successor past a subtree: climb over right children, then step right.
  assign idx_inc  = {1'b0, idx_r} + 1'b1;
  assign cand_inc = {1'b0, cand_r} + 1'b1;
  assign t_idx    = ctz(idx_inc);
  assign t_cand   = ctz(cand_inc);
  assign idx_tgt  = idx_inc >> t_idx;
  assign cand_tgt = cand_inc >> t_cand;

  // The candidate subtree is finished once all bits below the candidate are ones.
  assign lv_mask = ((NODE_W + 1)'(1) << (depth_r - dt_r)) - 1'b1;

  // Free path: node at the current depth that starts at the offset.
  assign off_l   = TREE_LEVELS'({{TREE_LEVELS{1'b0}}, off_r});
  assign off_sh  = off_l << depth_r;
  assign aligned = (off_sh == '0);
  assign fslot   = (NODE_W'(1) << depth_r) | (NODE_W'(off_l) >> (TREE_LEVELS - depth_r));

  assign gnode     = cmd.grant_here ? idx_r : cand_r;
  assign gnode_sh  = gnode << (TREE_LEVELS - dt_r);
  assign gnode_off = OFS_W'({{OFS_W{1'b0}}, gnode_sh[TREE_LEVELS-1:0]});

  assign push_off = (cmd_r == bta_pkg::CMD_FREE) ? (res_ok_r ? off_r : '0) : res_off_r;

  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt_r;
    wdata = 1'b0;
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.grant_here || cmd.grant_cand) begin
      we    = 1'b1;
      waddr = gnode;
      wdata = 1'b1;
    end else if (cmd.fr_apply && aligned) begin
      we    = 1'b1;
      waddr = fslot;
    end
  end

  assign raddr = (cmd_r == bta_pkg::CMD_FREE) ? fslot : idx_r;

  always_ff @(posedge clk) begin
    if (we) begin
      node_used_mem[waddr] <= wdata;
    end
    rd_data_r <= node_used_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_tuser;
      size_r    <= in_tdata[bta_pkg::REQ_SIZE_W-1:0];
      off_r     <= in_tdata[bta_pkg::REQ_SIZE_W +: OFS_W];
      whole_r   <= POOL_BYTES;
      dt_r      <= '0;
      depth_r   <= '0;
      res_ok_r  <= 1'b0;
      res_off_r <= '0;
    end
    if (cmd.lvl_step) begin
      dt_r    <= dt_r + 1'b1;
      whole_r <= whole_r >> 1;
    end
    if (cmd.walk_start) begin
      idx_r   <= NODE_W'(1);
      depth_r <= '0;
    end
    if (cmd.mark_cand) begin
      cand_r <= idx_r;
    end
    if (cmd.descend) begin
      idx_r   <= {idx_r[NODE_W-2:0], 1'b0};
      depth_r <= depth_r + 1'b1;
    end
    if (cmd.skip) begin
      idx_r   <= idx_tgt[NODE_W-1:0];
      depth_r <= depth_r - t_idx;
    end
    if (cmd.skip_cand) begin
      idx_r   <= cand_tgt[NODE_W-1:0];
      depth_r <= dt_r - t_cand;
    end
    if (cmd.grant_here || cmd.grant_cand) begin
      res_ok_r  <= 1'b1;
      res_off_r <= gnode_off;
    end
    if (cmd.fr_apply && aligned && rd_data_r) begin
      res_ok_r <= 1'b1;
    end
    if (cmd.fr_next) begin
      depth_r <= depth_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data_r <= {1'b0, push_off, res_ok_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign status.clr_done   = (clr_cnt_r == '1);
  assign status.is_free    = (cmd_r == bta_pkg::CMD_FREE);
  assign status.req_ok     = (size_r != '0) && (size_ext <= POOL_BYTES);
  assign status.off_ok     = ((off_r >> TREE_LEVELS) == '0);
  assign status.lvl_hit    = ((whole_r >> 1) < size_ext) || (whole_r == size_ext) ||
                             (dt_r == DEP_W'(TREE_LEVELS));
  assign status.used       = rd_data_r;
  assign status.below      = (depth_r < dt_r);
  assign status.at_cand    = (depth_r == dt_r);
  assign status.at_leaf    = (depth_r == DEP_W'(TREE_LEVELS));
  assign status.leave_cand = ((idx_inc & lv_mask) == '0);
  assign status.skip_end   = (idx_tgt == (NODE_W + 1)'(1));
  assign status.cand_end   = (cand_tgt == (NODE_W + 1)'(1));
  assign status.out_free   = !out_valid_r || out_tready;

endmodule

// File: rtl/core/bta_ctrl.sv
`timescale 1ns / 1ps

module bta_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  bta_pkg::dp_status_t status,
  output bta_pkg::dp_cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_START = 9'b000000100,
    ST_LEVEL = 9'b000001000,
    ST_READ  = 9'b000010000,
    ST_CHECK = 9'b000100000,
    ST_FRD   = 9'b001000000,
    ST_FWR   = 9'b010000000,
    ST_PUSH  = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (status.is_free) begin
          state_nxt = status.off_ok ? ST_FRD : ST_PUSH;
        end else begin
          state_nxt = status.req_ok ? ST_LEVEL : ST_PUSH;
        end
      end
      ST_LEVEL: begin
        if (status.lvl_hit) begin
          cmd.walk_start = 1'b1;
          state_nxt      = ST_READ;
        end else begin
          cmd.lvl_step = 1'b1;
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = ST_READ;
        if (status.below) begin
          // Above the grant level: a used node shuts off its whole subtree.
          if (status.used) begin
            cmd.skip = 1'b1;
            if (status.skip_end) begin
              state_nxt = ST_PUSH;
            end
          end else begin
            cmd.descend = 1'b1;
          end
        end else if (status.at_cand) begin
          if (status.used) begin
            cmd.skip = 1'b1;
            if (status.skip_end) begin
              state_nxt = ST_PUSH;
            end
          end else if (status.at_leaf) begin
            cmd.grant_here = 1'b1;
            state_nxt      = ST_PUSH;
          end else begin
            cmd.mark_cand = 1'b1;
            cmd.descend   = 1'b1;
          end
        end else begin
          // Inside a candidate: any used node rejects the candidate.
          if (status.used) begin
            cmd.skip_cand = 1'b1;
            if (status.cand_end) begin
              state_nxt = ST_PUSH;
            end
          end else if (!status.at_leaf) begin
            cmd.descend = 1'b1;
          end else if (status.leave_cand) begin
            cmd.grant_cand = 1'b1;
            state_nxt      = ST_PUSH;
          end else begin
            cmd.skip = 1'b1;
          end
        end
      end
      ST_FRD: begin
        state_nxt = ST_FWR;
      end
      ST_FWR: begin
        cmd.fr_apply = 1'b1;
        if (status.at_leaf) begin
          state_nxt = ST_PUSH;
        end else begin
          cmd.fr_next = 1'b1;
          state_nxt   = ST_FRD;
        end
      end
      ST_PUSH: begin
        if (status.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/core/bta_checker.sv
`timescale 1ns / 1ps

module bta_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bta_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Each accepted request makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted in back-to-back cycles");

  // The store is still being cleared right after reset.
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_tready)
    else $error("request taken during clearing pass");

  // A new result only appears while the block is working on a request.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while idle");

  // A refused request carries a zero offset.
  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[6:1] == '0)
    else $error("offset set on refused request");

endmodule

bind buddy_tree_allocator bta_checker u_bta_checker (.*);

// File: test/buddy_tree_allocator_tb.sv
`timescale 1ns / 1ps

module buddy_tree_allocator_tb;

  localparam int          LEVELS     = bta_pkg::TREE_LEVELS_DEF;
  localparam int unsigned LEAF       = bta_pkg::LEAF_BYTES_DEF;
  localparam int unsigned POOL_BYTES = LEAF << LEVELS;
  localparam int unsigned NODES      = 2 << LEVELS;
  localparam int          DRAIN_CYC  = 300;

  typedef struct packed {
    logic                         granted;
    logic [bta_pkg::OFFSET_W-1:0] offset;
  } alloc_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [bta_pkg::IN_DATA_W-1:0]  in_tdata = '0;   // request_size, free_offset
  logic                           in_tuser = bta_pkg::CMD_ALLOC;  // command
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [bta_pkg::OUT_DATA_W-1:0] out_tdata;       // granted, block_offset

  // Predicted copy of the allocation tree, one used bit per node.
  bit                           node_busy [0:NODES-1];
  alloc_result_t                expected_results [$];
  logic [bta_pkg::OFFSET_W-1:0] live_offsets [$];
  int unsigned                  mismatch_count = 0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_len       = 0;
  logic        recv_hold      = 1'b0;

  buddy_tree_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [bta_pkg::OFFSET_W-1:0] block_start(int unsigned node,
                                                               int unsigned depth);
    return bta_pkg::OFFSET_W'((node - (1 << depth)) << (LEVELS - depth));
  endfunction

  function automatic bit subtree_idle(int unsigned node, int unsigned depth);
    if (node_busy[node]) return 1'b0;
    if (depth >= LEVELS) return 1'b1;
    return subtree_idle(2 * node, depth + 1) && subtree_idle(2 * node + 1, depth + 1);
  endfunction

  // Preorder search for a free block that suits the request; marks it used.
  function automatic bit find_block(int unsigned bytes, int unsigned node, int unsigned depth,
                                    output logic [bta_pkg::OFFSET_W-1:0] off);
    longint unsigned whole;
    off = '0;
    if (node_busy[node]) return 1'b0;
    if (depth >= LEVELS) begin
      node_busy[node] = 1'b1;
      off = block_start(node, depth);
      return 1'b1;
    end
    whole = longint'(LEAF) << (LEVELS - depth);
    if ((whole >> 1) < bytes || whole == bytes) begin
      if (!subtree_idle(node, depth)) return 1'b0;
      node_busy[node] = 1'b1;
      off = block_start(node, depth);
      return 1'b1;
    end
    if (find_block(bytes, 2 * node, depth + 1, off)) return 1'b1;
    return find_block(bytes, 2 * node + 1, depth + 1, off);
  endfunction

  function automatic alloc_result_t predict_request(logic cmd,
                                                    logic [bta_pkg::REQ_SIZE_W-1:0] bytes,
                                                    logic [bta_pkg::OFFSET_W-1:0] off);
    alloc_result_t                res;
    logic [bta_pkg::OFFSET_W-1:0] found;
    int unsigned                  span;
    int unsigned                  node;
    res = '0;
    if (cmd == bta_pkg::CMD_ALLOC) begin
      if (bytes != 0 && bytes <= POOL_BYTES) begin
        if (find_block(bytes, 1, 0, found)) begin
          res.granted = 1'b1;
          res.offset  = found;
        end
      end
    end else begin
      // Every node whose block starts at the offset is cleared.
      for (int d = 0; d <= LEVELS; d++) begin
        span = 1 << (LEVELS - d);
        if ((off & (span - 1)) == 0) begin
          node = (1 << d) + (off >> (LEVELS - d));
          if (node_busy[node]) res.granted = 1'b1;
          node_busy[node] = 1'b0;
        end
      end
      if (res.granted) res.offset = off;
    end
    return res;
  endfunction

  task automatic send_request(logic cmd, logic [bta_pkg::REQ_SIZE_W-1:0] bytes,
                              logic [bta_pkg::OFFSET_W-1:0] off);
    alloc_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, off, bytes};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = predict_request(cmd, bytes, off);
    expected_results.push_back(res);
    if (cmd == bta_pkg::CMD_ALLOC && res.granted) begin
      live_offsets.push_back(res.offset);
    end else if (cmd == bta_pkg::CMD_FREE) begin
      for (int i = live_offsets.size() - 1; i >= 0; i--) begin
        if (live_offsets[i] == off) live_offsets.delete(i);
      end
    end
  endtask

  always @(posedge clk) begin
    out_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Holds the result channel off for the length set in hold_len when a test asks for it.
  initial begin : pressure_ctrl
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        recv_hold <= 1'b1;
        repeat (hold_len) @(posedge clk);
        recv_hold <= 1'b0;
        hold_len = 0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    alloc_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: granted %0d, block_offset %0d",
               out_tdata[0], out_tdata[bta_pkg::OFFSET_W:1]);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tdata[0] !== exp_r.granted) begin
          $error("granted: expected %0d, actual %0d", exp_r.granted, out_tdata[0]);
          mismatch_count++;
        end
        if (out_tdata[bta_pkg::OFFSET_W:1] !== exp_r.offset) begin
          $error("block_offset: expected %0d, actual %0d", exp_r.offset,
                 out_tdata[bta_pkg::OFFSET_W:1]);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(bta_pkg::CMD_ALLOC, 32'd0, 6'd0);
    send_request(bta_pkg::CMD_ALLOC, POOL_BYTES + 1, 6'd63);
    send_request(bta_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 6'd0);
    send_request(bta_pkg::CMD_ALLOC, POOL_BYTES, 6'd0);
    send_request(bta_pkg::CMD_ALLOC, 32'd1, 6'd0);
    send_request(bta_pkg::CMD_FREE, 32'hFFFF_FFFF, 6'd0);
    send_request(bta_pkg::CMD_FREE, 32'd0, 6'd0);
    // A one-byte request walks all the way down to a leaf.
    send_request(bta_pkg::CMD_ALLOC, 32'd1, 6'd0);
    send_request(bta_pkg::CMD_ALLOC, LEAF, 6'd63);
    send_request(bta_pkg::CMD_ALLOC, LEAF + 1, 6'd0);
    send_request(bta_pkg::CMD_ALLOC, 3 * LEAF, 6'd0);
    send_request(bta_pkg::CMD_ALLOC, POOL_BYTES / 2, 6'd0);
    send_request(bta_pkg::CMD_ALLOC, POOL_BYTES / 2 + 1, 6'd0);
    send_request(bta_pkg::CMD_FREE, 32'd0, 6'd5);
    send_request(bta_pkg::CMD_FREE, 32'd0, 6'd4);
    send_request(bta_pkg::CMD_FREE, 32'd0, 6'd2);
    send_request(bta_pkg::CMD_FREE, 32'd0, 6'd1);
    send_request(bta_pkg::CMD_FREE, 32'd0, 6'd32);
    send_request(bta_pkg::CMD_FREE, 32'd0, 6'd63);
    send_request(bta_pkg::CMD_FREE, 32'd0, 6'd0);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned                    pick;
    int unsigned                    k;
    logic [bta_pkg::REQ_SIZE_W-1:0] bytes;
    logic [bta_pkg::OFFSET_W-1:0]   off;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      off  = bta_pkg::OFFSET_W'($urandom());
      if (pick < 55) begin
        k = $urandom_range(0, LEVELS);
        if ($urandom_range(0, 1)) k = $urandom_range(0, k);
        case ($urandom_range(0, 2))
          0: bytes = LEAF << k;
          1: bytes = (k == 0) ? $urandom_range(1, LEAF)
                              : $urandom_range((LEAF << (k - 1)) + 1, LEAF << k);
          default: bytes = (LEAF << k) - $urandom_range(0, 1);
        endcase
        send_request(bta_pkg::CMD_ALLOC, bytes, off);
      end else if (pick < 92) begin
        if (pick < 85 && live_offsets.size() != 0) begin
          off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
        end
        send_request(bta_pkg::CMD_FREE, $urandom(), off);
      end else begin
        case ($urandom_range(0, 2))
          0: bytes = '0;
          1: bytes = $urandom_range(POOL_BYTES + 1, 32'hFFFF_FFFF);
          default: bytes = $urandom();
        endcase
        send_request(bta_pkg::CMD_ALLOC, bytes, off);
      end
    end
  endtask

  task automatic test_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(200);
  endtask

  task automatic test_sender_idle();
    send_idle_pct  = 59;
    recv_stall_pct = 0;
    run_random(190);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 59;
    run_random(190);
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 18;
    recv_stall_pct = 18;
    run_random(190);
  endtask

  // The result channel is held off while requests keep coming, so the input stalls.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = 600;
    run_random(12);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bta_pkg.sv
rtl/core/bta_dpath.sv
rtl/core/bta_ctrl.sv
rtl/core/buddy_tree_allocator.sv
rtl/core/bta_checker.sv
test/buddy_tree_allocator_tb.sv
